[rtl/bit_packer_varint_encoder_defines.svh]
// Assertion macros shared by the bit packer RTL.
`ifndef BIT_PACKER_VARINT_ENCODER_DEFINES_SVH
`define BIT_PACKER_VARINT_ENCODER_DEFINES_SVH

// Checks that a property holds at every clock edge outside reset.
`define BPVE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bit packer assertion failed");

// Checks that a consequent holds in the same cycle as its antecedent.
`define BPVE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    `BPVE_ASSERT(label, clk, rst_n, (ante) |-> (cons))

`endif

[rtl/bpve_pkg.sv]
package bpve_pkg;

    localparam logic [2:0] OP_START  = 3'd0;
    localparam logic [2:0] OP_RAW    = 3'd1;
    localparam logic [2:0] OP_NUMBER = 3'd2;
    localparam logic [2:0] OP_SKIP   = 3'd3;
    localparam logic [2:0] OP_FINISH = 3'd4;

    localparam logic [1:0] REG_FIRST_BITS = 2'd0;
    localparam logic [1:0] REG_NEXT_BITS  = 2'd1;
    localparam logic [1:0] REG_BUF_BYTES  = 2'd2;
    localparam logic [1:0] REG_START_OFF  = 2'd3;

    localparam logic [2:0]  FIRST_BITS_RST = 3'd4;
    localparam logic [2:0]  NEXT_BITS_RST  = 3'd5;
    localparam logic [16:0] BUF_BYTES_RST  = 17'h10000;
    localparam logic [15:0] START_OFF_RST  = 16'h0000;

    localparam logic [2:0] MIN_CHUNK_BITS = 3'd2;
    localparam logic [3:0] BYTE_BITS      = 4'd8;

    typedef logic [7:0] t_mask_tab [0:8];
    localparam t_mask_tab LOW_MASK = '{8'h00, 8'h01, 8'h03, 8'h07, 8'h0f,
                                       8'h1f, 8'h3f, 8'h7f, 8'hff};

    typedef struct packed {
        logic [2:0]  first_bits;
        logic [2:0]  next_bits;
        logic [16:0] buf_bytes;
        logic [15:0] start_off;
    } t_cfg;

    typedef struct packed {
        logic [7:0] emit_byte;
        logic [7:0] next_byte;
        logic [3:0] next_free;
        logic       adv;
    } t_put_res;

endpackage

[rtl/bpve_cfg_regs.sv]
module bpve_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output bpve_pkg::t_cfg      o_cfg
);

    bpve_pkg::t_cfg r_cfg;
    logic           w_wr;

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_bits <= bpve_pkg::FIRST_BITS_RST;
            r_cfg.next_bits  <= bpve_pkg::NEXT_BITS_RST;
            r_cfg.buf_bytes  <= bpve_pkg::BUF_BYTES_RST;
            r_cfg.start_off  <= bpve_pkg::START_OFF_RST;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                bpve_pkg::REG_FIRST_BITS: r_cfg.first_bits <= pwdata[2:0];
                bpve_pkg::REG_NEXT_BITS:  r_cfg.next_bits  <= pwdata[2:0];
                bpve_pkg::REG_BUF_BYTES:  r_cfg.buf_bytes  <= pwdata[16:0];
                bpve_pkg::REG_START_OFF:  r_cfg.start_off  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            bpve_pkg::REG_FIRST_BITS: prdata = 32'(r_cfg.first_bits);
            bpve_pkg::REG_NEXT_BITS:  prdata = 32'(r_cfg.next_bits);
            bpve_pkg::REG_BUF_BYTES:  prdata = 32'(r_cfg.buf_bytes);
            bpve_pkg::REG_START_OFF:  prdata = 32'(r_cfg.start_off);
            default:                  prdata = 32'd0;
        endcase
    end

endmodule

[rtl/bpve_chunk.sv]
module bpve_chunk #(
    parameter int VALUE_BITS = 64
) (
    input  logic [VALUE_BITS-1:0] i_val,
    input  logic [2:0]            i_width,
    output logic [7:0]            o_chunk,
    output logic [3:0]            o_bits,
    output logic [VALUE_BITS-1:0] o_rest
);

    logic w_more;

    assign o_rest  = i_val >> i_width;
    assign w_more  = |o_rest;
    assign o_chunk = (i_val[7:0] & bpve_pkg::LOW_MASK[4'(i_width)])
                   | (8'(w_more) << i_width);
    assign o_bits  = 4'(i_width) + 4'd1;

endmodule

[rtl/bpve_put_unit.sv]
module bpve_put_unit (
    input  logic [7:0]              i_cur_byte,
    input  logic [3:0]              i_free,
    input  logic [7:0]              i_v,
    input  logic [3:0]              i_bits,
    output bpve_pkg::t_put_res      o_res
);

    logic [15:0] w_sh;
    logic [7:0]  w_or;
    logic        w_fits;

    assign w_sh   = 16'(i_v) << (bpve_pkg::BYTE_BITS - i_free);
    assign w_or   = i_cur_byte | w_sh[7:0];
    assign w_fits = i_bits <= i_free;

    always_comb begin
        o_res.emit_byte = w_or;
        o_res.adv       = !w_fits;
        if (w_fits) begin
            o_res.next_byte = w_or;
            o_res.next_free = i_free - i_bits;
        end else begin
            o_res.next_byte = i_v >> i_free;
            o_res.next_free = bpve_pkg::BYTE_BITS - i_bits + i_free;
        end
    end

endmodule

[rtl/bit_packer_varint_encoder.sv]
// Bit packer with chunked variable-length integer encoder.
// Commands arrive on the s_axis channel: tuser carries the op code, tdata the
// value and the raw field width. Packed bytes leave on m_axis with their buffer
// address; tlast marks the byte of a finish command and tuser the overflow flag.
// The APB port holds the chunk widths, the buffer size and the start offset;
// a start command latches the buffer size and the start offset.
// A command is taken only while the block is idle. It then runs in steps: one
// step for start, skip, finish and raw writes, one step per chunk for a number;
// raw writes and number chunks pass through the shared bit-insert unit. A
// produced byte appears on m_axis in the cycle after its step.
// Results pass through a single output register. While that register holds a
// byte the receiver has not taken, every step waits, whether it emits or not.
// Reset performs a start with the reset register values and empties the
// output register.
`include "bit_packer_varint_encoder_defines.svh"

module bit_packer_varint_encoder #(
    parameter int ADDR_BITS  = 16,
    parameter int VALUE_BITS = 64,
    localparam int S_TDATA_W = ((VALUE_BITS + 4 + 7) / 8) * 8,
    localparam int M_TDATA_W = ((ADDR_BITS + 8 + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // value, then bit_count (4 bits), zero padding.
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // op (3 bits).
    input  logic [2:0]           i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // byte_addr, then byte_value (8 bits), zero padding.
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    output logic                 o_m_axis_tlast,
    // overflow (1 bit).
    output logic                 o_m_axis_tuser,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int AW1 = ADDR_BITS + 1;
    localparam int CW  = (AW1 > 17) ? AW1 : 17;
    localparam int SW  = (VALUE_BITS > AW1) ? VALUE_BITS : AW1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    bpve_pkg::t_cfg     w_cfg;
    bpve_pkg::t_put_res w_put;

    logic                  r_state, n_state;
    logic [2:0]            r_op, n_op;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [3:0]            r_bits, n_bits;
    logic                  r_first, n_first;
    logic [ADDR_BITS-1:0]  r_cur_addr, n_cur_addr;
    logic [AW1-1:0]        r_next_addr, n_next_addr;
    logic [AW1-1:0]        r_end_addr, n_end_addr;
    logic [3:0]            r_free, n_free;
    logic [7:0]            r_byte, n_byte;
    logic                  r_ok, n_ok;
    logic                  r_out_valid, n_out_valid;
    logic [ADDR_BITS-1:0]  r_out_addr, n_out_addr;
    logic [7:0]            r_out_byte, n_out_byte;
    logic                  r_out_last, n_out_last;
    logic                  r_out_ovf, n_out_ovf;

    logic [16:0]           w_src_bytes;
    logic [15:0]           w_src_off;
    logic [CW-1:0]         w_sz;
    logic                  w_sz_nz;
    logic                  w_st_ok;
    logic [ADDR_BITS-1:0]  w_st_cur;
    logic [AW1-1:0]        w_st_next;
    logic [AW1-1:0]        w_st_end;

    logic [2:0]            w_fw, w_nw, w_cw;
    logic [7:0]            w_chunk;
    logic [3:0]            w_chunk_bits;
    logic [VALUE_BITS-1:0] w_rest;
    logic [3:0]            w_raw_bits;
    logic [7:0]            w_put_v;
    logic [3:0]            w_put_bits;
    logic                  w_adv_fail;
    logic [AW1-1:0]        w_room;
    logic                  w_skip_fits;
    logic                  w_slot_free;
    logic                  w_step;

    bpve_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bpve_chunk #(
        .VALUE_BITS (VALUE_BITS)
    ) u_chunk (
        .i_val   (r_val),
        .i_width (w_cw),
        .o_chunk (w_chunk),
        .o_bits  (w_chunk_bits),
        .o_rest  (w_rest)
    );

    bpve_put_unit u_put (
        .i_cur_byte (r_byte),
        .i_free     (r_free),
        .i_v        (w_put_v),
        .i_bits     (w_put_bits),
        .o_res      (w_put)
    );

    // Start values, taken from the reset register values while in reset.
    always_comb begin
        w_src_bytes = i_rst_n ? w_cfg.buf_bytes : bpve_pkg::BUF_BYTES_RST;
        w_src_off   = i_rst_n ? w_cfg.start_off : bpve_pkg::START_OFF_RST;
        w_sz        = CW'(w_src_bytes);
        if (w_sz > (CW'(1) << ADDR_BITS)) begin
            w_sz = CW'(1) << ADDR_BITS;
        end
        w_sz_nz = w_sz != '0;
        if (!w_sz_nz) begin
            w_sz = CW'(1);
        end
        w_st_ok  = w_sz_nz && (CW'(w_src_off) < w_sz);
        w_st_end = w_sz[AW1-1:0];
        if (w_st_ok) begin
            w_st_cur  = ADDR_BITS'(w_src_off);
            w_st_next = AW1'(w_src_off) + AW1'(1);
        end else begin
            w_st_cur  = '0;
            w_st_next = w_st_end;
        end
    end

    always_comb begin
        w_fw       = (w_cfg.first_bits < bpve_pkg::MIN_CHUNK_BITS)
                   ? bpve_pkg::MIN_CHUNK_BITS : w_cfg.first_bits;
        w_nw       = (w_cfg.next_bits < bpve_pkg::MIN_CHUNK_BITS)
                   ? bpve_pkg::MIN_CHUNK_BITS : w_cfg.next_bits;
        w_cw       = r_first ? w_fw : w_nw;
        w_raw_bits = (r_bits > bpve_pkg::BYTE_BITS) ? bpve_pkg::BYTE_BITS : r_bits;
        if (r_op == bpve_pkg::OP_NUMBER) begin
            w_put_v    = w_chunk;
            w_put_bits = w_chunk_bits;
        end else begin
            w_put_v    = r_val[7:0] & bpve_pkg::LOW_MASK[w_raw_bits];
            w_put_bits = w_raw_bits;
        end
        w_adv_fail  = w_put.adv && (r_next_addr >= r_end_addr);
        w_room      = r_end_addr - r_next_addr;
        w_skip_fits = SW'(r_val) <= SW'(w_room);
        w_slot_free = !r_out_valid || i_m_axis_tready;
        w_step      = (r_state == ST_EXEC) && w_slot_free;
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_val       = r_val;
        n_bits      = r_bits;
        n_first     = r_first;
        n_cur_addr  = r_cur_addr;
        n_next_addr = r_next_addr;
        n_end_addr  = r_end_addr;
        n_free      = r_free;
        n_byte      = r_byte;
        n_ok        = r_ok;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_addr  = r_out_addr;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;

        if (r_state == ST_IDLE) begin
            if (i_s_axis_tvalid) begin
                n_op    = i_s_axis_tuser;
                n_val   = i_s_axis_tdata[VALUE_BITS-1:0];
                n_bits  = i_s_axis_tdata[VALUE_BITS+3:VALUE_BITS];
                n_first = 1'b1;
                n_state = ST_EXEC;
            end
        end else if (w_step) begin
            n_state = ST_IDLE;
            unique case (r_op)
                bpve_pkg::OP_START: begin
                    n_cur_addr  = w_st_cur;
                    n_next_addr = w_st_next;
                    n_end_addr  = w_st_end;
                    n_ok        = w_st_ok;
                    n_free      = bpve_pkg::BYTE_BITS;
                    n_byte      = '0;
                end
                bpve_pkg::OP_FINISH: begin
                    n_out_valid = 1'b1;
                    n_out_addr  = r_cur_addr;
                    n_out_byte  = r_ok ? r_byte : 8'd0;
                    n_out_last  = 1'b1;
                    n_out_ovf   = !r_ok;
                end
                bpve_pkg::OP_RAW, bpve_pkg::OP_NUMBER: begin
                    if (r_ok && (w_put_bits != 4'd0)) begin
                        if (w_adv_fail) begin
                            n_ok = 1'b0;
                        end else begin
                            if (w_put.adv) begin
                                n_out_valid = 1'b1;
                                n_out_addr  = r_cur_addr;
                                n_out_byte  = w_put.emit_byte;
                                n_out_last  = 1'b0;
                                n_out_ovf   = 1'b0;
                                n_cur_addr  = r_next_addr[ADDR_BITS-1:0];
                                n_next_addr = r_next_addr + AW1'(1);
                            end
                            n_byte = w_put.next_byte;
                            n_free = w_put.next_free;
                            if ((r_op == bpve_pkg::OP_NUMBER) && (w_rest != '0)) begin
                                n_val   = w_rest;
                                n_first = 1'b0;
                                n_state = ST_EXEC;
                            end
                        end
                    end
                end
                bpve_pkg::OP_SKIP: begin
                    if (r_ok) begin
                        if (w_skip_fits) begin
                            n_next_addr = r_next_addr + AW1'(r_val);
                        end else begin
                            n_next_addr = r_end_addr;
                            n_ok        = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_first     <= 1'b1;
            r_cur_addr  <= w_st_cur;
            r_next_addr <= w_st_next;
            r_end_addr  <= w_st_end;
            r_ok        <= w_st_ok;
            r_free      <= bpve_pkg::BYTE_BITS;
            r_byte      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_first     <= n_first;
            r_cur_addr  <= n_cur_addr;
            r_next_addr <= n_next_addr;
            r_end_addr  <= n_end_addr;
            r_ok        <= n_ok;
            r_free      <= n_free;
            r_byte      <= n_byte;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_val      <= n_val;
        r_bits     <= n_bits;
        r_out_addr <= n_out_addr;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = M_TDATA_W'({r_out_byte, r_out_addr});
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_ovf;

    `BPVE_ASSERT(a_free_range, i_clk, i_rst_n, r_free <= bpve_pkg::BYTE_BITS)
    `BPVE_ASSERT(a_next_in_buf, i_clk, i_rst_n, r_next_addr <= r_end_addr)
    `BPVE_ASSERT_IMPL(a_ok_order, i_clk, i_rst_n, r_ok, AW1'(r_cur_addr) < r_next_addr)
    `BPVE_ASSERT_IMPL(a_ovf_last, i_clk, i_rst_n, r_out_valid && r_out_ovf, r_out_last)

endmodule

[test/bpve_byte_checker.sv]
`timescale 1ns / 1ps

module bpve_byte_checker
    import bpve_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    // value (64 bits), then bit_count (4 bits), zero padding.
    input  logic [71:0] i_s_tdata,
    // op (3 bits).
    input  logic [2:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // byte_addr (16 bits), then byte_value (8 bits).
    input  logic [23:0] i_m_tdata,
    input  logic        i_m_tlast,
    // overflow (1 bit).
    input  logic        i_m_tuser,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_mismatches,
    output int          o_pending
);

    typedef struct packed {
        logic [15:0] addr;
        logic [7:0]  data;
        logic        last;
        logic        ovf;
    } t_out_byte;

    t_out_byte   byte_q[$];
    t_cfg        cfg;
    logic [15:0] cur_addr;
    logic [16:0] next_addr;
    logic [16:0] end_addr;
    int          free_bits;
    logic [7:0]  cur_byte;
    logic        stream_ok;
    int          mismatches = 0;

    function automatic logic [7:0] low_bits(input int n);
        return 8'((1 << n) - 1);
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] exp_val,
                                   input logic [15:0] got_val);
        $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, exp_val, got_val);
        mismatches++;
    endtask

    task automatic push_byte(input logic [15:0] a, input logic [7:0] d, input logic l,
                             input logic o);
        byte_q.push_back('{addr: a, data: d, last: l, ovf: o});
    endtask

    task automatic start_stream();
        logic [16:0] size;
        logic        valid;
        size = cfg.buf_bytes;
        valid = 1'b1;
        if (size > 17'h10000) begin
            size = 17'h10000;
        end
        if (size == 17'd0) begin
            valid = 1'b0;
            size = 17'd1;
        end
        stream_ok = valid && ({1'b0, cfg.start_off} < size);
        end_addr = size;
        if (stream_ok) begin
            cur_addr = cfg.start_off;
            next_addr = {1'b0, cfg.start_off} + 17'd1;
        end else begin
            cur_addr = 16'd0;
            next_addr = end_addr;
        end
        free_bits = 8;
        cur_byte = 8'd0;
    endtask

    task automatic move_to_next_byte(output bit moved);
        if (next_addr >= end_addr) begin
            stream_ok = 1'b0;
            moved = 1'b0;
        end else begin
            push_byte(cur_addr, cur_byte, 1'b0, 1'b0);
            cur_addr = next_addr[15:0];
            next_addr = next_addr + 17'd1;
            moved = 1'b1;
        end
    endtask

    task automatic pack_bits(input logic [7:0] v, input int n);
        logic [7:0] f;
        bit         moved;
        f = v & low_bits(n);
        if (n <= free_bits) begin
            cur_byte = cur_byte | 8'(f << (8 - free_bits));
            free_bits = free_bits - n;
        end else if (free_bits == 0) begin
            move_to_next_byte(moved);
            if (!moved) return;
            cur_byte = f;
            free_bits = 8 - n;
        end else begin
            cur_byte = cur_byte | 8'(f << (8 - free_bits));
            move_to_next_byte(moved);
            if (!moved) return;
            cur_byte = f >> free_bits;
            free_bits = 8 - n + free_bits;
        end
    endtask

    task automatic pack_chunk(input logic [63:0] v, input int w);
        logic [7:0] c;
        c = v[7:0] & low_bits(w);
        if (v > 64'(low_bits(w))) begin
            c = c | 8'(1 << w);
        end
        pack_bits(c, w + 1);
    endtask

    task automatic encode_number(input logic [63:0] v);
        int fw;
        int nw;
        fw = (cfg.first_bits < MIN_CHUNK_BITS) ? int'(MIN_CHUNK_BITS) : int'(cfg.first_bits);
        nw = (cfg.next_bits < MIN_CHUNK_BITS) ? int'(MIN_CHUNK_BITS) : int'(cfg.next_bits);
        pack_chunk(v, fw);
        v = v >> fw;
        while (v != 64'd0 && stream_ok) begin
            pack_chunk(v, nw);
            v = v >> nw;
        end
    endtask

    task automatic apply_command(input logic [2:0] op, input logic [63:0] value,
                                 input logic [3:0] count);
        case (op)
            OP_START: begin
                start_stream();
            end
            OP_FINISH: begin
                if (stream_ok) begin
                    push_byte(cur_addr, cur_byte, 1'b1, 1'b0);
                end else begin
                    push_byte(cur_addr, 8'd0, 1'b1, 1'b1);
                end
            end
            OP_RAW: begin
                if (stream_ok && count != 4'd0) begin
                    pack_bits(value[7:0], (count > 4'd8) ? 8 : int'(count));
                end
            end
            OP_NUMBER: begin
                if (stream_ok) begin
                    encode_number(value);
                end
            end
            OP_SKIP: begin
                if (stream_ok) begin
                    if (value <= 64'(end_addr) - 64'(next_addr)) begin
                        next_addr = next_addr + value[16:0];
                    end else begin
                        next_addr = end_addr;
                        stream_ok = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_out_byte want;
        if (!i_rst_n) begin
            cfg = '{first_bits: FIRST_BITS_RST, next_bits: NEXT_BITS_RST,
                    buf_bytes: BUF_BYTES_RST, start_off: START_OFF_RST};
            start_stream();
            byte_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_FIRST_BITS: cfg.first_bits = i_pwdata[2:0];
                    REG_NEXT_BITS:  cfg.next_bits = i_pwdata[2:0];
                    REG_BUF_BYTES:  cfg.buf_bytes = i_pwdata[16:0];
                    REG_START_OFF:  cfg.start_off = i_pwdata[15:0];
                    default: begin
                    end
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                apply_command(i_s_tuser, i_s_tdata[63:0], i_s_tdata[67:64]);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (byte_q.size() == 0) begin
                    report_mismatch("Unexpected byte, address", 16'hxxxx, i_m_tdata[15:0]);
                end else begin
                    want = byte_q.pop_front();
                    if (i_m_tdata[15:0] !== want.addr) begin
                        report_mismatch("Byte address", want.addr, i_m_tdata[15:0]);
                    end
                    if (i_m_tdata[23:16] !== want.data) begin
                        report_mismatch("Byte value", 16'(want.data), 16'(i_m_tdata[23:16]));
                    end
                    if (i_m_tlast !== want.last) begin
                        report_mismatch("Last flag", 16'(want.last), 16'(i_m_tlast));
                    end
                    if (i_m_tuser !== want.ovf) begin
                        report_mismatch("Overflow flag", 16'(want.ovf), 16'(i_m_tuser));
                    end
                end
            end
        end
        o_pending <= byte_q.size();
        o_mismatches <= mismatches;
    end

endmodule

[test/bit_packer_varint_encoder_test.sv]
`timescale 1ns / 1ps

module bit_packer_varint_encoder_test;

    import bpve_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [71:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;

    logic        s_tready;
    logic        m_tvalid;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int pending;
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int hold_req = 0;
    int holds_done = 0;

    bit_packer_varint_encoder uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .o_m_axis_tuser  (m_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    bpve_byte_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .i_m_tuser    (m_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (holds_done != hold_req) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                holds_done++;
            end else if (rx_steady) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 38);
            end
        end
    end

    task automatic send_cmd(input logic [2:0] op, input logic [63:0] value,
                            input logic [3:0] count);
        if (!tx_steady && $urandom_range(99) < 38) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 38);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, count, value};
        s_tuser <= op;
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (64) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    function automatic logic [63:0] rand_number();
        logic [63:0] v;
        v = {$urandom, $urandom};
        if ($urandom_range(15) == 0) begin
            v = '1;
        end else begin
            v = v >> $urandom_range(63);
        end
        return v;
    endfunction

    task automatic random_stream(input int n);
        int          r;
        logic [63:0] v;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            v = {$urandom, $urandom};
            if (r < 8) begin
                send_cmd(3'($urandom_range(7)), v, 4'($urandom_range(15)));
            end else if (r < 45) begin
                send_cmd(OP_RAW, v, 4'($urandom_range(8, 1)));
            end else if (r < 85) begin
                send_cmd(OP_NUMBER, rand_number(), 4'($urandom_range(15)));
            end else if (r < 92) begin
                if ($urandom_range(7) == 0) begin
                    send_cmd(OP_SKIP, v, 4'd0);
                end else begin
                    send_cmd(OP_SKIP, 64'($urandom_range(3)), 4'd0);
                end
            end else if (r < 96) begin
                send_cmd(OP_FINISH, v, 4'd0);
            end else begin
                send_cmd(OP_START, v, 4'd0);
            end
        end
    endtask

    task automatic run_phase(input logic [2:0] first_bits, input logic [2:0] next_bits,
                             input logic [16:0] buf_bytes, input logic [15:0] start_off,
                             input int n, input bit steady, input bit hold);
        write_reg(REG_FIRST_BITS, 32'(first_bits));
        write_reg(REG_NEXT_BITS, 32'(next_bits));
        write_reg(REG_BUF_BYTES, 32'(buf_bytes));
        write_reg(REG_START_OFF, 32'(start_off));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        tx_steady = steady;
        rx_steady = steady;
        if (hold) begin
            hold_req++;
        end
        send_cmd(OP_START, 64'd0, 4'd0);
        random_stream(n);
        send_cmd(OP_FINISH, 64'd0, 4'd0);
        drain();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: widths 4 and 5, full buffer from address zero.
        send_cmd(OP_RAW, 64'h1, 4'd1);
        send_cmd(OP_RAW, '1, 4'd8);
        send_cmd(OP_RAW, 64'h5, 4'd0);
        send_cmd(OP_RAW, 64'hA5, 4'd15);
        send_cmd(OP_NUMBER, 64'd0, 4'd0);
        send_cmd(OP_NUMBER, 64'd15, 4'd0);
        send_cmd(OP_NUMBER, 64'd16, 4'd0);
        send_cmd(OP_NUMBER, '1, 4'd0);
        send_cmd(OP_SKIP, 64'd0, 4'd0);
        send_cmd(OP_FINISH, 64'd0, 4'd0);
        send_cmd(OP_FINISH, 64'd0, 4'd0);
        send_cmd(OP_SKIP, 64'd3, 4'd0);
        send_cmd(3'd5, '1, 4'd3);
        send_cmd(3'd6, 64'h1234, 4'd8);
        send_cmd(3'd7, 64'h0, 4'd1);
        send_cmd(OP_RAW, 64'h6, 4'd3);
        send_cmd(OP_SKIP, '1, 4'd0);
        send_cmd(OP_RAW, 64'hFF, 4'd8);
        send_cmd(OP_NUMBER, 64'd1000, 4'd0);
        send_cmd(OP_SKIP, 64'd1, 4'd0);
        send_cmd(OP_FINISH, 64'd0, 4'd0);
        send_cmd(OP_START, 64'd0, 4'd0);
        send_cmd(OP_NUMBER, 64'h8000_0000_0000_0000, 4'd0);
        send_cmd(OP_FINISH, 64'd0, 4'd0);
        drain();

        run_phase(3'd2, 3'd2, 17'h10000, 16'd0, 45, 1'b0, 1'b1);
        run_phase(3'd7, 3'd7, 17'h10000, 16'hFFFF, 20, 1'b0, 1'b0);
        run_phase(3'd3, 3'd6, 17'd0, 16'd0, 12, 1'b0, 1'b0);
        run_phase(3'd3, 3'd6, 17'h1FFFF, 16'd100, 45, 1'b1, 1'b0);
        run_phase(3'd5, 3'd3, 17'd40, 16'd10, 45, 1'b0, 1'b0);
        run_phase(3'd6, 3'd4, 17'd20, 16'd20, 10, 1'b0, 1'b0);
        run_phase(3'd1, 3'd0, 17'h10000, 16'd500, 40, 1'b0, 1'b0);
        run_phase(3'd0, 3'd1, 17'd1000, 16'd999, 12, 1'b0, 1'b0);
        run_phase(3'd7, 3'd2, 17'd3, 16'd2, 25, 1'b0, 1'b0);
        run_phase(3'd4, 3'd5, 17'h10000, 16'd0, 40, 1'b0, 1'b0);

        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

[bit_packer_varint_encoder.f]
+incdir+rtl
rtl/bpve_pkg.sv
rtl/bpve_cfg_regs.sv
rtl/bpve_chunk.sv
rtl/bpve_put_unit.sv
rtl/bit_packer_varint_encoder.sv
test/bpve_byte_checker.sv
test/bit_packer_varint_encoder_test.sv
